// ===== rtl/uart_fifo_xon_xoff_flow_control_core_macros.svh =====
// assertion macros for the uart fifo flow control core
`ifndef UART_FIFO_XON_XOFF_FLOW_CONTROL_CORE_MACROS_SVH
`define UART_FIFO_XON_XOFF_FLOW_CONTROL_CORE_MACROS_SVH

`ifndef SYNTHESIS
// checked on clk, off while arst_n is low
`define UFFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on clk, also during reset
`define UFFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UFFC_ASSERT(lbl, prop, msg)
`define UFFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/uffc_pkg.sv =====
// types and constants of the uart fifo flow control core
package uffc_pkg;

	localparam int THR_W = 9;
	localparam logic [THR_W-1:0] THR_RESET = 9'd32;

	localparam logic [7:0] XOFF_CHAR = 8'h13;
	localparam logic [7:0] XON_CHAR  = 8'h11;

	typedef enum logic [1:0] {
		MODE_HOST_WRITE = 2'd0,
		MODE_LINE_RECV  = 2'd1,
		MODE_LINE_READY = 2'd2,
		MODE_HOST_READ  = 2'd3
	} mode_t;

	// source of the byte sent on the line
	typedef enum logic [1:0] {
		LS_NONE = 2'd0,
		LS_XOFF = 2'd1,
		LS_XON  = 2'd2,
		LS_DATA = 2'd3
	} line_sel_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       line_valid;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       refused;
		logic [7:0] rx_level;
		logic       tx_busy;
		logic       remote_on;
	} res_t;

endpackage

// ===== rtl/uffc_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module uffc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/uart_fifo_xon_xoff_flow_control_core.sv =====
// uart receive/transmit ring fifos with xon/xoff flow control
//
//  channel   ports                       handshake
//  request   start, busy, req            taken when start=1 and busy=0
//  result    done, res                   registered, in the cycle after the request, one cycle wide
//  config    cfg_we, cfg_wdata           threshold written when cfg_we=1
//
// one request per cycle; busy stays low
// the result comes in the cycle after its request, set by the registered ram read port
// pointers, counts and flags update at the request edge, so back-to-back requests
// see each other's writes through the ram without forwarding
// reset clears pointers, count, xoff pending and remote, and sets xon pending; ram contents are not cleared
// the result cannot be held off by the receiver
`include "uart_fifo_xon_xoff_flow_control_core_macros.svh"

module uart_fifo_xon_xoff_flow_control_core #(
	parameter int RX_DEPTH = 256,
	parameter int TX_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  uffc_pkg::req_t             req,
	output logic                       done,
	output uffc_pkg::res_t             res,
	input  logic                       cfg_we,
	input  logic [uffc_pkg::THR_W-1:0] cfg_wdata
);

	import uffc_pkg::*;

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int OW    = $clog2(RX_DEPTH + 1);
	localparam int CMPW  = (OW > THR_W) ? OW : THR_W;

	function automatic logic [RX_AW-1:0] rx_adv(input logic [RX_AW-1:0] p);
		rx_adv = (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TX_AW-1:0] tx_adv(input logic [TX_AW-1:0] p);
		tx_adv = (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [RX_AW-1:0] rx_head_q, rx_tail_q, rx_count_q;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q;
	logic             xoff_pend_q, xon_pend_q, remote_q;
	logic [THR_W-1:0] thr_q;

	logic [RX_AW-1:0] rx_head_n, rx_tail_n, rx_count_n;
	logic [TX_AW-1:0] tx_head_n, tx_tail_n;
	logic             xoff_pend_n, xon_pend_n, remote_n;

	logic             accept;
	logic             rx_we, rx_re, tx_we, tx_re;
	logic [7:0]       rx_rdata, tx_rdata;
	line_sel_t        line_sel;
	logic             rd_valid, refused;
	logic [RX_AW-1:0] cnt_inc, cnt_dec;
	logic [OW-1:0]    open_inc, open_dec;

	logic             valid_s1;
	line_sel_t        line_sel_s1;
	logic             rd_valid_s1, refused_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign cnt_inc  = rx_count_q + 1'b1;
	assign cnt_dec  = rx_count_q - 1'b1;
	assign open_inc = OW'(RX_DEPTH) - OW'(cnt_inc);
	assign open_dec = OW'(RX_DEPTH) - OW'(cnt_dec);

	always_comb begin
		rx_head_n   = rx_head_q;
		rx_tail_n   = rx_tail_q;
		rx_count_n  = rx_count_q;
		tx_head_n   = tx_head_q;
		tx_tail_n   = tx_tail_q;
		xoff_pend_n = xoff_pend_q;
		xon_pend_n  = xon_pend_q;
		remote_n    = remote_q;
		rx_we       = 1'b0;
		rx_re       = 1'b0;
		tx_we       = 1'b0;
		tx_re       = 1'b0;
		line_sel    = LS_NONE;
		rd_valid    = 1'b0;
		refused     = 1'b0;
		if (accept) begin
			case (req.mode)
				MODE_HOST_WRITE: begin
					if (tx_adv(tx_head_q) == tx_tail_q) begin
						refused = 1'b1;
					end else begin
						tx_we     = 1'b1;
						tx_head_n = tx_adv(tx_head_q);
					end
				end
				MODE_LINE_RECV: begin
					if (rx_adv(rx_head_q) == rx_tail_q) begin
						refused = 1'b1;
					end else begin
						rx_we      = 1'b1;
						rx_head_n  = rx_adv(rx_head_q);
						rx_count_n = cnt_inc;
						if (remote_q && (CMPW'(open_inc) <= CMPW'(thr_q))) begin
							xoff_pend_n = 1'b1;
						end
					end
				end
				MODE_LINE_READY: begin
					if (xoff_pend_q) begin
						line_sel    = LS_XOFF;
						xoff_pend_n = 1'b0;
						remote_n    = 1'b0;
					end else if (xon_pend_q) begin
						line_sel   = LS_XON;
						xon_pend_n = 1'b0;
						remote_n   = 1'b1;
					end else if (tx_head_q != tx_tail_q) begin
						line_sel  = LS_DATA;
						tx_re     = 1'b1;
						tx_tail_n = tx_adv(tx_tail_q);
					end
				end
				MODE_HOST_READ: begin
					if (rx_head_q != rx_tail_q) begin
						rd_valid   = 1'b1;
						rx_re      = 1'b1;
						rx_tail_n  = rx_adv(rx_tail_q);
						rx_count_n = cnt_dec;
						if (!remote_q && (CMPW'(open_dec) > CMPW'(thr_q))) begin
							xon_pend_n = 1'b1;
						end
					end
				end
				default: begin
					refused = 1'b0;
				end
			endcase
		end
	end

	uffc_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_head_q),
		.wdata (req.data_byte),
		.re    (rx_re),
		.raddr (rx_tail_q),
		.rdata (rx_rdata)
	);

	uffc_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_head_q),
		.wdata (req.data_byte),
		.re    (tx_re),
		.raddr (tx_tail_q),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			rx_count_q  <= '0;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			xoff_pend_q <= 1'b0;
			xon_pend_q  <= 1'b1;
			remote_q    <= 1'b0;
			thr_q       <= THR_RESET;
			valid_s1    <= 1'b0;
		end else begin
			rx_head_q   <= rx_head_n;
			rx_tail_q   <= rx_tail_n;
			rx_count_q  <= rx_count_n;
			tx_head_q   <= tx_head_n;
			tx_tail_q   <= tx_tail_n;
			xoff_pend_q <= xoff_pend_n;
			xon_pend_q  <= xon_pend_n;
			remote_q    <= remote_n;
			valid_s1    <= accept;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		line_sel_s1 <= line_sel;
		rd_valid_s1 <= rd_valid;
		refused_s1  <= refused;
	end

	// state registers already hold the after-request values while done is high
	always_comb begin
		res = '0;
		case (line_sel_s1)
			LS_XOFF: res.line_byte = XOFF_CHAR;
			LS_XON:  res.line_byte = XON_CHAR;
			LS_DATA: res.line_byte = tx_rdata;
			default: res.line_byte = 8'd0;
		endcase
		res.line_valid = (line_sel_s1 != LS_NONE);
		res.read_byte  = rd_valid_s1 ? rx_rdata : 8'd0;
		res.read_valid = rd_valid_s1;
		res.refused    = refused_s1;
		res.rx_level   = 8'(rx_count_q);
		res.tx_busy    = xoff_pend_q || xon_pend_q || (tx_head_q != tx_tail_q);
		res.remote_on  = remote_q;
	end

	assign done = valid_s1;

	`UFFC_ASSERT(a_done_follows, (start && !busy) |=> done, "request without result")
	`UFFC_ASSERT(a_no_spurious_done, !(start && !busy) |=> !done, "result without request")
	`UFFC_ASSERT_ALWAYS(a_xoff_needs_remote, xoff_pend_q |-> remote_q, "xoff pending while remote off")
	`UFFC_ASSERT(a_remote_on_by_xon, $rose(remote_q) |-> (done && res.line_valid && (res.line_byte == XON_CHAR)), "remote on without xon sent")
	`UFFC_ASSERT(a_rx_count_ptrs, (rx_head_q >= rx_tail_q) ? (32'(rx_count_q) == 32'(rx_head_q) - 32'(rx_tail_q)) : (32'(rx_count_q) == RX_DEPTH + 32'(rx_head_q) - 32'(rx_tail_q)), "rx count out of step with pointers")

endmodule
